FILE: rtl/dru_pkg.sv
// ---------------------------------------------------------------------------
// dru_pkg
// Shared types, constants and character helpers for the record-to-text block.
// ---------------------------------------------------------------------------
package dru_pkg;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = QPTR_W + 1;

    // results one item can expand into
    localparam int MAX_RES = 5;
    localparam int RIDX_W  = $clog2(MAX_RES + 1);

    localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
    localparam logic [7:0] CH_UPA  = 8'h41;  // 'A'
    localparam logic [7:0] CH_PCT  = 8'h25;  // '%'
    localparam logic [7:0] CH_EQ   = 8'h3D;  // '='
    localparam logic [7:0] CH_SEMI = 8'h3B;  // ';'

    // one classified item, as passed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] dig_hund;
        logic [3:0] dig_tens;
        logic [3:0] dig_ones;
        logic       safe;
        logic       do_type;
        logic       do_data;
        logic       do_semi;
        logic       do_stat;
        logic       trunc;
        logic       last;
    } t_job;

    typedef struct packed {
        logic [7:0] out_char;
        logic       is_char;
        logic       truncated;
        logic       out_end;
    } t_res;

    function automatic logic is_safe(input logic [7:0] c);
        logic r;
        r = ((c >= 8'h61) && (c <= 8'h7A)) ||
            ((c >= 8'h41) && (c <= 8'h5A)) ||
            ((c >= 8'h30) && (c <= 8'h39)) ||
            (c == 8'h2E) || (c == 8'h2F) || (c == 8'h2D) ||
            (c == 8'h5F) || (c == 8'h24);
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = CH_ZERO + {4'd0, nib};
        end else begin
            r = CH_UPA + {4'd0, nib} - 8'd10;
        end
        return r;
    endfunction

endpackage

FILE: rtl/dru_front.sv
// ---------------------------------------------------------------------------
// dru_front
// Accepts raw identifier bytes, tracks the record parse and emits one
// classified job per item that gives any result.
// ---------------------------------------------------------------------------
module dru_front import dru_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_full,
    output logic       o_stall,
    output logic       o_push,
    output t_job       o_job
);

    localparam logic [1:0] PH_TYPE = 2'd0;
    localparam logic [1:0] PH_LEN1 = 2'd1;
    localparam logic [1:0] PH_LEN2 = 2'd2;
    localparam logic [1:0] PH_DATA = 2'd3;

    logic [1:0]  r_phase, n_phase;
    logic [14:0] r_remain, n_remain;
    logic [6:0]  r_len_hi, n_len_hi;

    logic        accept;
    logic [1:0]  dig_hund;
    logic [6:0]  below_hund;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [3:0]  ones;
    logic [14:0] len_full;
    logic [14:0] remain_dec;
    t_job        job;

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;

    // split the type byte into decimal digits
    always_comb begin
        if (i_byte >= 8'd200) begin
            dig_hund   = 2'd2;
            below_hund = 7'(i_byte - 8'd200);
        end else if (i_byte >= 8'd100) begin
            dig_hund   = 2'd1;
            below_hund = 7'(i_byte - 8'd100);
        end else begin
            dig_hund   = 2'd0;
            below_hund = i_byte[6:0];
        end
    end

    // divide by ten through the reciprocal, exact below one hundred
    assign tens_prod = {8'd0, below_hund} * 15'd205;
    assign tens      = tens_prod[14:11];
    assign ones      = 4'(below_hund - 7'({3'd0, tens} * 7'd10));

    assign len_full   = {r_len_hi, 8'd0} >> 1;
    assign remain_dec = (r_remain != 15'd0) ? r_remain - 15'd1 : r_remain;

    always_comb begin
        logic [14:0] len2;
        len2          = len_full + {7'd0, i_byte};
        n_phase       = r_phase;
        n_remain      = r_remain;
        n_len_hi      = r_len_hi;
        job.data_byte = i_byte;
        job.dig_hund  = dig_hund;
        job.dig_tens  = tens;
        job.dig_ones  = ones;
        job.safe      = is_safe(i_byte);
        job.do_type   = 1'b0;
        job.do_data   = 1'b0;
        job.do_semi   = 1'b0;
        job.do_stat   = 1'b0;
        job.trunc     = 1'b0;
        job.last      = i_last;
        case (r_phase)
            PH_TYPE: begin
                job.do_type = 1'b1;
                n_phase     = PH_LEN1;
            end
            PH_LEN1: begin
                if (i_byte[7]) begin
                    n_len_hi = i_byte[6:0];
                    n_phase  = PH_LEN2;
                end else if (i_byte == 8'd0) begin
                    job.do_semi = 1'b1;
                    n_phase     = PH_TYPE;
                end else begin
                    n_remain = {7'd0, i_byte};
                    n_phase  = PH_DATA;
                end
            end
            PH_LEN2: begin
                n_remain = len2;
                if (len2 == 15'd0) begin
                    job.do_semi = 1'b1;
                    n_phase     = PH_TYPE;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            default: begin
                job.do_data = 1'b1;
                n_remain    = remain_dec;
                if (remain_dec == 15'd0) begin
                    job.do_semi = 1'b1;
                    n_phase     = PH_TYPE;
                end
            end
        endcase
        if (i_last) begin
            job.trunc   = (n_phase != PH_TYPE);
            job.do_stat = (n_phase != PH_TYPE) ||
                          !(job.do_type || job.do_data || job.do_semi);
            // end of identifier: start afresh
            n_phase  = PH_TYPE;
            n_remain = 15'd0;
            n_len_hi = 7'd0;
        end
    end

    assign o_job  = job;
    assign o_push = accept && (job.do_type || job.do_data || job.do_semi || job.do_stat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TYPE;
            r_remain <= 15'd0;
            r_len_hi <= 7'd0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_remain <= n_remain;
            r_len_hi <= n_len_hi;
        end
    end

endmodule

FILE: rtl/dru_queue.sv
// ---------------------------------------------------------------------------
// dru_queue
// Short job queue between the front and back halves.
// ---------------------------------------------------------------------------
module dru_queue import dru_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("job pushed into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("job popped from empty queue");
    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0 && r_cnt != QCNT_W'(QDEPTH)) |-> (r_wr != r_rd))
        else $error("queue pointers disagree with count");
`endif

endmodule

FILE: rtl/dru_back.sv
// ---------------------------------------------------------------------------
// dru_back
// Expands the job at the queue head into text characters and status results,
// one per cycle while the output is not stalled, into a registered output stage.
// ---------------------------------------------------------------------------
module dru_back import dru_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_job i_job,
    input  logic i_empty,
    output logic o_pop,
    output logic o_valid,
    input  logic i_stall,
    output t_res o_res
);

    t_res              list [MAX_RES];
    logic [RIDX_W-1:0] count;
    logic [RIDX_W-1:0] r_idx;
    logic              r_valid;
    t_res              r_res;
    logic              load;
    logic              at_tail;

    always_comb begin
        logic [RIDX_W-1:0] k;
        k = '0;
        for (int i = 0; i < MAX_RES; i++) begin
            list[i] = '0;
        end
        if (i_job.do_type) begin
            if (i_job.dig_hund != 2'd0) begin
                list[k] = '{CH_ZERO + {6'd0, i_job.dig_hund}, 1'b1, 1'b0, 1'b0};
                k = k + 1'b1;
            end
            if (i_job.dig_hund != 2'd0 || i_job.dig_tens != 4'd0) begin
                list[k] = '{CH_ZERO + {4'd0, i_job.dig_tens}, 1'b1, 1'b0, 1'b0};
                k = k + 1'b1;
            end
            list[k] = '{CH_ZERO + {4'd0, i_job.dig_ones}, 1'b1, 1'b0, 1'b0};
            k = k + 1'b1;
            list[k] = '{CH_EQ, 1'b1, 1'b0, 1'b0};
            k = k + 1'b1;
        end
        if (i_job.do_data) begin
            if (i_job.safe) begin
                list[k] = '{i_job.data_byte, 1'b1, 1'b0, 1'b0};
                k = k + 1'b1;
            end else begin
                list[k] = '{CH_PCT, 1'b1, 1'b0, 1'b0};
                k = k + 1'b1;
                list[k] = '{hex_char(i_job.data_byte[7:4]), 1'b1, 1'b0, 1'b0};
                k = k + 1'b1;
                list[k] = '{hex_char(i_job.data_byte[3:0]), 1'b1, 1'b0, 1'b0};
                k = k + 1'b1;
            end
        end
        if (i_job.do_semi) begin
            list[k] = '{CH_SEMI, 1'b1, 1'b0, 1'b0};
            k = k + 1'b1;
        end
        if (i_job.do_stat) begin
            list[k] = '{8'd0, 1'b0, i_job.trunc, 1'b0};
            k = k + 1'b1;
        end
        // flag the final result of the identifier
        if (i_job.last && k != '0) begin
            list[k - 1'b1].out_end = 1'b1;
        end
        count = k;
    end

    assign load    = !i_empty && (!r_valid || !i_stall);
    assign at_tail = (r_idx + 1'b1 >= count);
    assign o_pop   = load && at_tail;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= list[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_tail ? '0 : r_idx + 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_status_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_res.is_char) |-> r_res.out_end)
        else $error("status result is not the last of the identifier");
    a_status_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_res.is_char) |-> (r_res.out_char == 8'd0))
        else $error("status result carries a character");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (r_idx < count))
        else $error("expansion index beyond job length");
`endif

endmodule

FILE: rtl/docid_record_to_url_text_core.sv
// An accepted item passes the job queue, then the output register, before its first
// character is offered. Results leave the output register one per cycle while not
// stalled; an item gives up to five results (up to four for an escaped data byte).
// A four-entry job queue lets input accepts run ahead of the character expansion.
// Reset (synchronous, active low) returns the parser to expecting a type byte,
// empties the queue and drops any pending result.
// ---------------------------------------------------------------------------
// docid_record_to_url_text_core
// Converts a binary document identifier record stream into its text form.
// ---------------------------------------------------------------------------
module docid_record_to_url_text_core import dru_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_char,
    output logic       o_is_char,
    output logic       o_truncated,
    output logic       o_out_end
);

    logic push, pop, full, empty;
    t_job job_in, job_head;
    t_res res;

    dru_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_byte  (i_in_byte),
        .i_last  (i_in_last),
        .i_full  (full),
        .o_stall (o_in_stall),
        .o_push  (push),
        .o_job   (job_in)
    );

    dru_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (job_head),
        .o_empty (empty)
    );

    dru_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (res)
    );

    assign o_out_char  = res.out_char;
    assign o_is_char   = res.is_char;
    assign o_truncated = res.truncated;
    assign o_out_end   = res.out_end;

endmodule

FILE: dv/tb_docid_record_to_url_text_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_docid_record_to_url_text_core
// Feeds record streams byte by byte and checks every emitted character, the
// truncation status and the end marker against a local model of the parser.
// ---------------------------------------------------------------------------
module tb_docid_record_to_url_text_core import dru_pkg::*; ();

    localparam int CYCLE_LIMIT = 200_000;
    localparam int RAND_ITEMS  = 150;
    localparam int IDLE_PCT    = 32;
    localparam int QUIET_LO    = 60;
    localparam int QUIET_HI    = 110;
    localparam int DRAIN_CYC   = 20;

    typedef enum logic [1:0] {REC_TYPE, REC_LEN1, REC_LEN2, REC_DATA} t_rec_phase;

    typedef struct {
        logic [7:0] id_byte;
        logic       id_last;
        bit         wait_drain;
    } t_byte_item;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_in_byte;
    logic       i_in_last;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_out_char;
    logic       o_is_char;
    logic       o_truncated;
    logic       o_out_end;

    t_byte_item byte_queue [$];
    t_res       expected_chars [$];

    t_rec_phase rec_phase;
    logic [14:0] rec_left;
    logic [6:0]  len_hi;

    string safe_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789./-_$";
    string hex_set  = "0123456789ABCDEF";

    int  cyc_count;
    int  n_acc;
    int  n_err;
    bit  in_done;

    docid_record_to_url_text_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_char  (o_out_char),
        .o_is_char   (o_is_char),
        .o_truncated (o_truncated),
        .o_out_end   (o_out_end)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit byte_is_safe(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == "." || c == "/" ||
               c == "-" || c == "_" || c == "$";
    endfunction

    function automatic t_res text_char(input logic [7:0] c);
        t_res r;
        r.out_char  = c;
        r.is_char   = 1'b1;
        r.truncated = 1'b0;
        r.out_end   = 1'b0;
        return r;
    endfunction

    function automatic bit quiet_stretch();
        return n_acc >= QUIET_LO && n_acc < QUIET_HI;
    endfunction

    // Work out the characters one accepted byte gives and queue them.
    task automatic predict_text(input logic [7:0] b, input logic last);
        t_res r [$];
        t_res s;
        r = {};
        case (rec_phase)
            REC_TYPE: begin
                if (b >= 8'd100) r.push_back(text_char("0" + b / 8'd100));
                if (b >= 8'd10) r.push_back(text_char("0" + (b / 8'd10) % 8'd10));
                r.push_back(text_char("0" + b % 8'd10));
                r.push_back(text_char("="));
                rec_phase = REC_LEN1;
            end
            REC_LEN1: begin
                if (b > 8'd127) begin
                    len_hi    = b[6:0];
                    rec_phase = REC_LEN2;
                end else if (b == 8'd0) begin
                    r.push_back(text_char(";"));
                    rec_phase = REC_TYPE;
                end else begin
                    rec_left  = {7'd0, b};
                    rec_phase = REC_DATA;
                end
            end
            REC_LEN2: begin
                rec_left = {1'b0, len_hi, 7'd0} + {7'd0, b};
                if (rec_left == 15'd0) begin
                    r.push_back(text_char(";"));
                    rec_phase = REC_TYPE;
                end else begin
                    rec_phase = REC_DATA;
                end
            end
            default: begin
                if (byte_is_safe(b)) begin
                    r.push_back(text_char(b));
                end else begin
                    r.push_back(text_char("%"));
                    r.push_back(text_char(hex_set[b[7:4]]));
                    r.push_back(text_char(hex_set[b[3:0]]));
                end
                if (rec_left > 15'd0) rec_left = rec_left - 15'd1;
                if (rec_left == 15'd0) begin
                    r.push_back(text_char(";"));
                    rec_phase = REC_TYPE;
                end
            end
        endcase
        if (last) begin
            // unfinished record, or nothing emitted: append a status-only result
            if (rec_phase != REC_TYPE || r.size() == 0) begin
                s.out_char  = 8'd0;
                s.is_char   = 1'b0;
                s.truncated = (rec_phase != REC_TYPE);
                s.out_end   = 1'b0;
                r.push_back(s);
            end
            s = r[r.size() - 1];
            s.out_end = 1'b1;
            r[r.size() - 1] = s;
            rec_phase = REC_TYPE;
            rec_left  = 15'd0;
            len_hi    = 7'd0;
        end
        foreach (r[k]) expected_chars.push_back(r[k]);
    endtask

    task automatic add_byte(input logic [7:0] b, input logic last, input bit drain);
        t_byte_item it;
        it.id_byte    = b;
        it.id_last    = last;
        it.wait_drain = drain;
        byte_queue.push_back(it);
    endtask

    // Input side: accept at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predict_text(i_in_byte, i_in_last);
            n_acc   <= n_acc + 1;
            in_done <= 1'b1;
        end else begin
            in_done <= 1'b0;
        end
    end

    // Input side: present the next item at the falling edge
    always @(negedge i_clk) begin : drv_feed
        bit idle;
        idle = !quiet_stretch() && ($urandom_range(99) < IDLE_PCT);
        if (i_rst_n && (!i_in_valid || in_done)) begin
            if (byte_queue.size() == 0 || idle ||
                (byte_queue[0].wait_drain && expected_chars.size() != 0)) begin
                i_in_valid <= 1'b0;
            end else begin
                i_in_byte  <= byte_queue[0].id_byte;
                i_in_last  <= byte_queue[0].id_last;
                i_in_valid <= 1'b1;
                void'(byte_queue.pop_front());
            end
        end
    end

    // Output side: random back-pressure
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            i_out_stall <= !quiet_stretch() && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Output side: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : mon_check
        t_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_chars.size() == 0) begin
                n_err = n_err + 1;
                if (n_err <= 10)
                    $display("unexpected result: char=%h is_char=%b trunc=%b end=%b",
                             o_out_char, o_is_char, o_truncated, o_out_end);
            end else begin
                want = expected_chars.pop_front();
                if (o_out_char !== want.out_char || o_is_char !== want.is_char ||
                    o_truncated !== want.truncated || o_out_end !== want.out_end) begin
                    n_err = n_err + 1;
                    if (n_err <= 10)
                        $display("mismatch: exp char=%h is_char=%b trunc=%b end=%b,",
                                 want.out_char, want.is_char, want.truncated,
                                 want.out_end,
                                 " got char=%h is_char=%b trunc=%b end=%b",
                                 o_out_char, o_is_char, o_truncated, o_out_end);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc_count <= cyc_count + 1;
        if (cyc_count > CYCLE_LIMIT) begin
            $display("docid_record_to_url_text_core verification failed");
            $finish;
        end
    end

    initial begin : stim
        logic [7:0] rec_bytes [$];
        int n_rand;
        int id_count;
        int n_rec;
        int dlen;
        int cut;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_byte   = 8'd0;
        i_in_last   = 1'b0;
        i_out_stall = 1'b0;
        cyc_count   = 0;
        n_acc       = 0;
        n_err       = 0;
        in_done     = 1'b0;
        rec_phase   = REC_TYPE;
        rec_left    = 15'd0;
        len_hi      = 7'd0;

        // type 0 with zero length, then a record with an escaped NUL
        add_byte(8'd0, 1'b0, 1'b0);
        add_byte(8'd0, 1'b0, 1'b0);
        add_byte(8'd255, 1'b0, 1'b0);
        add_byte(8'd2, 1'b0, 1'b0);
        add_byte("a", 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        // record complete on the last byte
        add_byte(8'd9, 1'b0, 1'b0);
        add_byte(8'd1, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b1, 1'b0);
        // end straight after a type byte
        add_byte(8'd100, 1'b1, 1'b0);
        // end inside a two-byte length: no characters from that step
        add_byte(8'd7, 1'b0, 1'b0);
        add_byte(8'h80, 1'b1, 1'b0);
        // two-byte zero length, then the largest length cut short
        add_byte(8'd42, 1'b0, 1'b0);
        add_byte(8'h80, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'd1, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte("$", 1'b0, 1'b0);
        add_byte(8'h7E, 1'b1, 1'b0);
        add_byte(8'd200, 1'b0, 1'b0);
        add_byte(8'd1, 1'b0, 1'b0);
        add_byte("z", 1'b1, 1'b0);

        // well-formed identifiers with random content, a few cut short
        n_rand   = 0;
        id_count = 0;
        while (n_rand < RAND_ITEMS) begin
            rec_bytes = {};
            n_rec = $urandom_range(1, 3);
            for (int k = 0; k < n_rec; k++) begin
                rec_bytes.push_back(8'($urandom_range(255)));
                dlen = $urandom_range(0, 5);
                if ($urandom_range(4) == 0) rec_bytes.push_back(8'h80);
                rec_bytes.push_back(8'(dlen));
                for (int j = 0; j < dlen; j++) begin
                    if ($urandom_range(1) == 0)
                        rec_bytes.push_back(safe_set[$urandom_range(safe_set.len() - 1)]);
                    else
                        rec_bytes.push_back(8'($urandom_range(255)));
                end
            end
            cut = rec_bytes.size();
            if ($urandom_range(9) == 0) cut = $urandom_range(1, rec_bytes.size());
            for (int j = 0; j < cut; j++)
                add_byte(rec_bytes[j], j == cut - 1, j == 0 && id_count % 8 == 0);
            n_rand   = n_rand + cut;
            id_count = id_count + 1;
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_queue.size() != 0 || i_in_valid || expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (n_err == 0 && expected_chars.size() == 0) begin
            $display("docid_record_to_url_text_core verification clean");
        end else begin
            $display("docid_record_to_url_text_core verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/dru_pkg.sv
rtl/dru_front.sv
rtl/dru_queue.sv
rtl/dru_back.sv
rtl/docid_record_to_url_text_core.sv
dv/tb_docid_record_to_url_text_core.sv
